// ===== sv/kmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// kmsf_pkg: shared types and constants for the key matrix scanner
// Holds default geometry, field widths and the operation record that the
// front part hands to the back part.
// ----------------------------------------------------------------------------
package kmsf_pkg;

  localparam int RowsDef      = 4;
  localparam int ColsDef      = 4;
  localparam int FifoDepthDef = 8;

  // Fixed by the payload fields.
  localparam int RowFieldBits = 4;
  localparam int MapBits      = 16;
  localparam int DriveBits    = 2;
  localparam int CountBits    = 4;

  // Operation passed from the front part to the back part.
  typedef struct packed {
    logic                 is_pop;
    logic                 push;
    logic [MapBits-1:0]   keys;
    logic [DriveBits-1:0] drive_column;
  } kmsf_op_t;

endpackage

// ===== sv/kmsf_front.sv =====
// ----------------------------------------------------------------------------
// kmsf_front: scan front part
// Accepts sample and pop requests, assembles the column scans into a key
// bitmap and decides whether a finished scan must be pushed.
// ----------------------------------------------------------------------------
module kmsf_front
  import kmsf_pkg::*;
#(
  parameter int ROWS = RowsDef,
  parameter int COLS = ColsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [RowFieldBits-1:0] row_levels_i,
  output logic                    op_valid_o,
  input  logic                    op_ready_i,
  output kmsf_op_t                op_o
);

  localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int DW  = (CIW > DriveBits) ? CIW : DriveBits;

  logic [CIW-1:0]     col_q, col_d;
  logic [MapBits-1:0] partial_q, partial_d;
  logic [MapBits-1:0] prev_q, prev_d;
  logic [MapBits-1:0] hits;
  logic [MapBits-1:0] scan;
  logic [DW-1:0]      drive_wide;
  logic               accept;
  logic               last_col;
  logic               changed;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign accept     = in_valid_i && op_ready_i;

  always_comb begin
    int b;
    b    = 0;
    hits = '0;
    for (int r = 0; r < RowFieldBits; r++) begin
      b = COLS * r + int'(col_q);
      if ((r < ROWS) && !row_levels_i[r] && (b < MapBits)) begin
        hits[b[3:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    scan      = partial_q | hits;
    last_col  = (col_q == CIW'(COLS - 1));
    changed   = (scan != prev_q);
    col_d     = col_q;
    partial_d = partial_q;
    prev_d    = prev_q;
    if (!mode_i) begin
      if (last_col) begin
        col_d     = '0;
        partial_d = '0;
        if (changed) begin
          prev_d = scan;
        end
      end else begin
        col_d     = col_q + CIW'(1);
        partial_d = scan;
      end
    end
    drive_wide      = DW'(col_d);
    op_o.is_pop       = mode_i;
    op_o.push         = !mode_i && last_col && changed && (scan != '0);
    op_o.keys         = scan;
    op_o.drive_column = drive_wide[DriveBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      partial_q <= '0;
      prev_q    <= '0;
    end else if (accept) begin
      col_q     <= col_d;
      partial_q <= partial_d;
      prev_q    <= prev_d;
    end
  end

endmodule

// ===== sv/kmsf_queue.sv =====
// ----------------------------------------------------------------------------
// kmsf_queue: two-entry operation queue
// Decouples the scan front part from the FIFO back part so that either side
// can stall without stopping the other.
// ----------------------------------------------------------------------------
module kmsf_queue
  import kmsf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  kmsf_op_t wr_op_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output kmsf_op_t rd_op_o
);

  kmsf_op_t   slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_op_o    = slot_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== sv/kmsf_back.sv =====
// ----------------------------------------------------------------------------
// kmsf_back: event FIFO back part
// Carries out push and pop operations on the key event FIFO and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module kmsf_back
  import kmsf_pkg::*;
#(
  parameter int FIFO_DEPTH = FifoDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  output logic                 op_ready_o,
  input  kmsf_op_t             op_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DriveBits-1:0] drive_column_o,
  output logic                 popped_valid_o,
  output logic [MapBits-1:0]   popped_keys_o,
  output logic [CountBits-1:0] fifo_count_o,
  output logic                 dropped_o
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FW = $clog2(FIFO_DEPTH + 1);
  localparam int CW = (FW > CountBits) ? FW : CountBits;

  logic [MapBits-1:0]   mem [FIFO_DEPTH];
  logic [AW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [FW-1:0]        fill_q, fill_d;
  logic [CW-1:0]        fill_wide;
  logic                 out_valid_q;
  logic [DriveBits-1:0] drive_q;
  logic                 pvalid_q;
  logic [MapBits-1:0]   keys_q;
  logic [CountBits-1:0] count_q;
  logic                 dropped_q;
  logic                 fire;
  logic                 full;
  logic                 empty;
  logic                 do_push;
  logic                 do_pop;

  assign fire       = op_valid_i && (!out_valid_q || out_ready_i);
  assign op_ready_o = !out_valid_q || out_ready_i;
  assign full       = (fill_q == FW'(FIFO_DEPTH));
  assign empty      = (fill_q == '0);
  assign do_push    = fire && !op_i.is_pop && op_i.push && !full;
  assign do_pop     = fire && op_i.is_pop && !empty;

  always_comb begin
    fill_d = fill_q;
    if (do_push) begin
      fill_d = fill_q + FW'(1);
    end else if (do_pop) begin
      fill_d = fill_q - FW'(1);
    end
    fill_wide = CW'(fill_d);
  end

  // The head entry is read straight into the output register.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= op_i.keys;
    end
    if (fire) begin
      drive_q   <= op_i.drive_column;
      pvalid_q  <= do_pop;
      count_q   <= fill_wide[CountBits-1:0];
      dropped_q <= !op_i.is_pop && op_i.push && full;
      if (do_pop) begin
        keys_q <= mem[rd_ptr_q];
      end else begin
        keys_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      fill_q <= fill_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_column_o = drive_q;
  assign popped_valid_o = pvalid_q;
  assign popped_keys_o  = keys_q;
  assign fifo_count_o   = count_q;
  assign dropped_o      = dropped_q;

endmodule

// ===== sv/key_matrix_scan_fifo.sv =====
// ----------------------------------------------------------------------------
// key_matrix_scan_fifo: key matrix scanner with key event FIFO
// Path: the edge that accepts a request writes the operation queue, and the
// result is loaded into the output register once the back part is ready.
// Throughput: one request per cycle while out_ready_i lets results drain.
// Reset clears the scan state, FIFO pointers and fill count; the FIFO
// memory itself is not cleared, since no entry is read before it is written.
// ----------------------------------------------------------------------------
module key_matrix_scan_fifo
  import kmsf_pkg::*;
#(
  parameter int ROWS       = RowsDef,
  parameter int COLS       = ColsDef,
  parameter int FIFO_DEPTH = FifoDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [RowFieldBits-1:0] row_levels_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DriveBits-1:0]    drive_column_o,
  output logic                    popped_valid_o,
  output logic [MapBits-1:0]      popped_keys_o,
  output logic [CountBits-1:0]    fifo_count_o,
  output logic                    dropped_o
);

  logic     f_valid, f_ready;
  kmsf_op_t f_op;
  logic     b_valid, b_ready;
  kmsf_op_t b_op;

  kmsf_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .row_levels_i(row_levels_i),
    .op_valid_o  (f_valid),
    .op_ready_i  (f_ready),
    .op_o        (f_op)
  );

  kmsf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_op_i   (f_op),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_op_o   (b_op)
  );

  kmsf_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (b_valid),
    .op_ready_o    (b_ready),
    .op_i          (b_op),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_column_o(drive_column_o),
    .popped_valid_o(popped_valid_o),
    .popped_keys_o (popped_keys_o),
    .fifo_count_o  (fifo_count_o),
    .dropped_o     (dropped_o)
  );

endmodule
